@@ rtl/core/iis_pkg.sv @@
// ----------------------------------------------------------------------------
// iis_pkg
// Shared types and constants for the integral image stream block.
// ----------------------------------------------------------------------------
package iis_pkg;

  localparam int AREA_W = 36;   // summed-area result width
  localparam int REG_W  = 11;   // frame size register width
  localparam int ADDR_W = 3;    // APB byte address width
  localparam int DATA_W = 32;   // APB data width

  localparam logic [REG_W-1:0] SIZE_RESET = 11'd1024;

  // register index, taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic [AREA_W-1:0] area_t;
  typedef logic [REG_W-1:0]  size_reg_t;

endpackage

@@ rtl/core/integral_image_stream.sv @@
// ----------------------------------------------------------------------------
// integral_image_stream
// Summed-area table of a raster-order pixel stream, one result per pixel.
// ----------------------------------------------------------------------------
// Pixels enter on in_valid/in_ready in raster order; each transfer yields one
// result on out_valid/out_ready: area_sum is the sum of all pixels of the
// frame at or above and at or left of that pixel, with row_end and frame_end
// marking the last pixel of a row and of the frame.
// Throughput is one pixel per clock without output stalls: the line store is
// read at acceptance and written as the pixel leaves the work stage, a single
// read and a single write port per cycle, with a forwarding path when the same
// column is read and written back to back (width of one). frame_width and
// frame_height are set over the APB port (offsets 0x0 and 0x4); the user must
// write them only while no pixel is in flight, which the block does not
// enforce. Zero counts as one, larger than the maximum saturates. Reset clears
// the position, running sum and pipeline and sets both sizes to 1024; the line
// store is not cleared, since the first row never reads it.
// When the receiver stalls, the output register holds its result, the work
// stage holds one more pixel, and in_ready drops only when both are full.
// ----------------------------------------------------------------------------
module integral_image_stream
  import iis_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // pixel input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIXEL_BITS-1:0] pixel,
  // result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [AREA_W-1:0]     area_sum,
  output logic                  row_end,
  output logic                  frame_end,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WCMP_W = (COL_W + 1 > REG_W) ? COL_W + 1 : REG_W;
  localparam int HCMP_W = (ROW_W + 1 > REG_W) ? ROW_W + 1 : REG_W;
  localparam int RSUM_W = (PIXEL_BITS + COL_W > AREA_W) ? AREA_W : PIXEL_BITS + COL_W;

  localparam logic [WCMP_W-1:0] MAX_W_CMP = WCMP_W'(MAX_WIDTH);
  localparam logic [HCMP_W-1:0] MAX_H_CMP = HCMP_W'(MAX_HEIGHT);

  // configuration registers
  size_reg_t frame_width;
  size_reg_t frame_height;

  // position and row sum
  logic [COL_W-1:0]  column_index;
  logic [ROW_W-1:0]  row_index;
  logic [RSUM_W-1:0] row_sum;

  // work stage
  logic              s1_valid;
  logic [COL_W-1:0]  s1_col;
  logic [RSUM_W-1:0] s1_rsum;
  logic              s1_top;
  logic              s1_last_col;
  logic              s1_last_row;
  logic              s1_fwd;
  area_t             s1_fwd_data;
  area_t             s1_rd_data;

  // line store
  area_t line_mem [MAX_WIDTH];

  logic              accept;
  logic              s1_adv;
  logic [WCMP_W-1:0] width_eff;
  logic [HCMP_W-1:0] height_eff;
  logic              last_col;
  logic              last_row;
  logic [RSUM_W-1:0] rsum_next;
  area_t             above;
  area_t             area;

  // --------------------------------------------------------------------------
  // APB registers
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= SIZE_RESET;
      frame_height <= SIZE_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width  <= pwdata[REG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Acceptance: position, row sum, line store read
  // --------------------------------------------------------------------------
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (frame_width == '0)
      width_eff = WCMP_W'(1);
    else if (WCMP_W'(frame_width) > MAX_W_CMP)
      width_eff = MAX_W_CMP;
    else
      width_eff = WCMP_W'(frame_width);

    if (frame_height == '0)
      height_eff = HCMP_W'(1);
    else if (HCMP_W'(frame_height) > MAX_H_CMP)
      height_eff = MAX_H_CMP;
    else
      height_eff = HCMP_W'(frame_height);
  end

  assign last_col  = (WCMP_W'(column_index) + WCMP_W'(1)) >= width_eff;
  assign last_row  = (HCMP_W'(row_index) + HCMP_W'(1)) >= height_eff;
  assign rsum_next = row_sum + RSUM_W'(pixel);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_index    <= '0;
      row_sum      <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        if (last_col) begin
          column_index <= '0;
          row_sum      <= '0;
          row_index    <= last_row ? '0 : row_index + ROW_W'(1);
        end else begin
          column_index <= column_index + COL_W'(1);
          row_sum      <= rsum_next;
        end
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // payload of the work stage; the previous item's write lands on the same
  // edge as this read, so a matching column is forwarded
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col      <= column_index;
      s1_rsum     <= rsum_next;
      s1_top      <= (row_index == '0);
      s1_last_col <= last_col;
      s1_last_row <= last_row;
      s1_fwd      <= s1_valid && (s1_col == column_index);
      s1_fwd_data <= area;
      s1_rd_data  <= line_mem[column_index];
    end
  end

  // --------------------------------------------------------------------------
  // Work stage: add the row above, write back, load the output register
  // --------------------------------------------------------------------------
  always_comb begin
    if (s1_top)
      above = '0;
    else if (s1_fwd)
      above = s1_fwd_data;
    else
      above = s1_rd_data;
  end

  assign area = above + AREA_W'(s1_rsum);

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_mem[s1_col] <= area;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      area_sum  <= area;
      row_end   <= s1_last_col;
      frame_end <= s1_last_col && s1_last_row;
    end
  end

endmodule

@@ rtl/core/iis_checker.sv @@
// ----------------------------------------------------------------------------
// iis_checker
// Port-level checks of the integral image stream, bound to the top level.
// ----------------------------------------------------------------------------
module iis_checker
  import iis_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [AREA_W-1:0] area_sum,
  input logic              row_end,
  input logic              frame_end,
  input logic              pready
);

  // the last pixel of a frame is always the last of its row
  a_frame_end_in_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (row_end || !frame_end))
    else $error("frame_end without row_end");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(area_sum)
      && $stable(row_end) && $stable(frame_end)))
    else $error("stalled result changed");

  // the block has room for a new pixel whenever the receiver took a transfer
  a_ready_after_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |-> in_ready)
    else $error("in_ready low while output drains");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind integral_image_stream iis_checker u_iis_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .area_sum  (area_sum),
  .row_end   (row_end),
  .frame_end (frame_end),
  .pready    (pready)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the summed-area table block. A short table of directed
// pixels and size writes goes first. Random frames of mostly small sizes
// follow, with one full-width row and mid-frame size changes. Every result
// is checked against its table value or a running summed-area predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import iis_pkg::*;

  localparam int PIX_W        = 16;
  localparam int MAX_W        = 1024;
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_ITEMS = 750;

  typedef struct packed {
    area_t area;
    logic  row_end;
    logic  frame_end;
  } result_t;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic             typed;
    result_t          want;
  } pix_item_t;

  typedef struct packed {
    logic             is_cfg;
    logic             reg_idx;
    size_reg_t        value;
    logic [PIX_W-1:0] px;
    logic             typed;
    result_t          want;
  } dir_row_t;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [PIX_W-1:0]  pixel     = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  area_t             area_sum;
  logic              row_end;
  logic              frame_end;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  integral_image_stream u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .pixel    (pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .area_sum (area_sum),
    .row_end  (row_end),
    .frame_end(frame_end),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // predictor state
  size_reg_t       cfg_width;
  size_reg_t       cfg_height;
  int unsigned     pos_col;
  int unsigned     pos_row;
  area_t           row_acc;
  area_t           line_sum [0:MAX_W-1];
  bit [MAX_W-1:0]  line_written;

  pix_item_t pend_q [$];
  result_t   sum_q [$];
  dir_row_t  dir_tab [$];

  pix_item_t held_item;
  pix_item_t next_item;
  result_t   step_res;
  result_t   got;
  result_t   want;
  int        send_idle = 36;
  int        recv_idle = 72;
  int        err_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic int unsigned eff_size(input size_reg_t v);
    if (v == 0) return 1;
    if (v > MAX_W) return MAX_W;
    return 32'(v);
  endfunction

  // one pixel through the summed-area recursion
  function automatic result_t area_step(input logic [PIX_W-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    area_t       above;
    result_t     r;
    logic        last_col;
    logic        last_row;
    w   = eff_size(cfg_width);
    h   = eff_size(cfg_height);
    col = (pos_col >= MAX_W) ? MAX_W - 1 : pos_col;
    row_acc = row_acc + area_t'(px);
    above   = (pos_row != 0) ? line_sum[col] : '0;
    r.area  = above + row_acc;
    line_sum[col]     = r.area;
    line_written[col] = 1'b1;
    last_col    = (col + 1) >= w;
    last_row    = (pos_row + 1) >= h;
    r.row_end   = last_col;
    r.frame_end = last_col && last_row;
    if (last_col) begin
      pos_col = 0;
      row_acc = '0;
      pos_row = last_row ? 0 : pos_row + 1;
    end else begin
      pos_col = col + 1;
    end
    return r;
  endfunction

  // columns 0..n-1 all written since reset
  function automatic int written_span();
    int k;
    k = 0;
    while (k < MAX_W && line_written[k]) k++;
    return k;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic size_reg_t pick_size();
    case ($urandom_range(0, 15))
      0: return size_reg_t'(0);
      1: return size_reg_t'(1);
      2: return size_reg_t'(1024);
      3: return size_reg_t'(2047);
      4: return size_reg_t'($urandom_range(1025, 2046));
      5: return size_reg_t'($urandom_range(17, 1023));
      default: return size_reg_t'($urandom_range(2, 16));
    endcase
  endfunction

  function automatic dir_row_t pix_row(input logic [PIX_W-1:0] px, input logic typed,
                                       input area_t a, input logic re, input logic fe);
    dir_row_t r;
    r       = '0;
    r.px    = px;
    r.typed = typed;
    r.want  = {a, re, fe};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic idx, input size_reg_t val);
    dir_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.value   = val;
    return r;
  endfunction

  function automatic pix_item_t plain_item(input logic [PIX_W-1:0] px);
    pix_item_t it;
    it    = '0;
    it.px = px;
    return it;
  endfunction

  // returns on a falling edge once nothing is queued, in flight or owed
  task automatic wait_drained();
    do @(negedge clk);
    while (pend_q.size() != 0 || in_valid || sum_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input size_reg_t val);
    logic [DATA_W-1:0] word;
    word            = $urandom;
    word[REG_W-1:0] = val;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_FRAME_WIDTH) cfg_width = val;
    else cfg_height = val;
    @(negedge clk);
  endtask

  // 1x1 size makes the next pixel close its frame wherever the position is
  task automatic to_frame_start();
    wait_drained();
    cfg_write(REG_FRAME_WIDTH, 11'd1);
    cfg_write(REG_FRAME_HEIGHT, 11'd1);
    pend_q.push_back(plain_item(rand_pixel()));
    wait_drained();
  endtask

  // pixel side
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        step_res = area_step(held_item.px);
        sum_q.push_back(held_item.typed ? held_item.want : step_res);
      end
      if (!in_valid || in_ready) begin
        if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          next_item = pend_q.pop_front();
          in_valid  <= 1'b1;
          pixel     <= next_item.px;
          held_item <= next_item;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got = {area_sum, row_end, frame_end};
      if (sum_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected transfer: area_sum %0d row_end %0b frame_end %0b",
                   area_sum, row_end, frame_end);
      end else begin
        want = sum_q.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10)
            $display({"mismatch: area_sum exp %0d got %0d, row_end exp %0b got %0b,",
                      " frame_end exp %0b got %0b"},
                     want.area, got.area, want.row_end, got.row_end,
                     want.frame_end, got.frame_end);
        end
      end
    end
  end

  initial begin
    int        i;
    int        n;
    int        split;
    int        small_sent;
    size_reg_t wv;
    logic      big_row_done;
    dir_row_t  row;

    cfg_width    = SIZE_RESET;
    cfg_height   = SIZE_RESET;
    pos_col      = 0;
    pos_row      = 0;
    row_acc      = '0;
    line_written = '0;
    small_sent   = 0;
    big_row_done = 1'b0;

    // first row after reset: plain running sums
    dir_tab.push_back(pix_row(16'hFFFF, 1'b1, 36'd65535, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(16'hFFFF, 1'b1, 36'd131070, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(16'h0000, 1'b1, 36'd131070, 1'b0, 1'b0));
    // width of zero mid-row: counts as one, position past it ends the row
    dir_tab.push_back(cfg_row(REG_FRAME_WIDTH, 11'd0));
    dir_tab.push_back(pix_row(16'h0001, 1'b1, 36'd131071, 1'b1, 1'b0));
    dir_tab.push_back(pix_row(16'h0002, 1'b1, 36'd65537, 1'b1, 1'b0));
    // height of zero mid-frame: current pixel closes the frame
    dir_tab.push_back(cfg_row(REG_FRAME_HEIGHT, 11'd0));
    dir_tab.push_back(pix_row(16'h0003, 1'b1, 36'd65540, 1'b1, 1'b1));
    dir_tab.push_back(pix_row(16'h0005, 1'b1, 36'd5, 1'b1, 1'b1));
    // 2x2 frame of full-scale pixels
    dir_tab.push_back(cfg_row(REG_FRAME_WIDTH, 11'd2));
    dir_tab.push_back(cfg_row(REG_FRAME_HEIGHT, 11'd2));
    dir_tab.push_back(pix_row(16'hFFFF, 1'b1, 36'd65535, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(16'hFFFF, 1'b1, 36'd131070, 1'b1, 1'b0));
    dir_tab.push_back(pix_row(16'hFFFF, 1'b1, 36'd131070, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(16'hFFFF, 1'b1, 36'd262140, 1'b1, 1'b1));
    // saturated height, then cut short mid-frame
    dir_tab.push_back(cfg_row(REG_FRAME_WIDTH, 11'd3));
    dir_tab.push_back(cfg_row(REG_FRAME_HEIGHT, 11'd2047));
    dir_tab.push_back(pix_row(16'h8000, 1'b0, '0, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(16'h7FFF, 1'b0, '0, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(16'h0001, 1'b0, '0, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(16'hA5A5, 1'b0, '0, 1'b0, 1'b0));
    dir_tab.push_back(cfg_row(REG_FRAME_HEIGHT, 11'd1));
    dir_tab.push_back(pix_row(16'h5A5A, 1'b0, '0, 1'b0, 1'b0));
    dir_tab.push_back(pix_row(16'hFFFF, 1'b0, '0, 1'b0, 1'b0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < dir_tab.size(); i++) begin
      row = dir_tab[i];
      if (row.is_cfg) begin
        wait_drained();
        cfg_write(row.reg_idx, row.value);
      end else begin
        pend_q.push_back({row.px, row.typed, row.want});
      end
    end

    while (small_sent < RANDOM_ITEMS) begin
      if (small_sent < RANDOM_ITEMS / 3) begin
        send_idle = 36;
        recv_idle = 72;
      end else if (small_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle = 72;
        recv_idle = 36;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end

      // one full-width row as a frame of its own, saturated width
      if (!big_row_done && small_sent >= 300) begin
        to_frame_start();
        cfg_write(REG_FRAME_WIDTH, 11'd2047);
        cfg_write(REG_FRAME_HEIGHT, 11'd1);
        for (n = 0; n < MAX_W; n++) pend_q.push_back(plain_item(rand_pixel()));
        big_row_done = 1'b1;
      end

      wait_drained();
      if ($urandom_range(0, 1)) begin
        wv = pick_size();
        // below the first row, never widen past columns written since reset
        if (pos_row != 0 && eff_size(wv) > written_span())
          wv = size_reg_t'(written_span());
        cfg_write(REG_FRAME_WIDTH, wv);
      end
      if ($urandom_range(0, 1))
        cfg_write(REG_FRAME_HEIGHT, pick_size());

      n     = $urandom_range(1, 40);
      split = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : n;
      for (i = 0; i < n; i++) begin
        if (i == split) wait_drained();
        pend_q.push_back(plain_item(rand_pixel()));
      end
      small_sent += n;
    end

    wait_drained();
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
